/* src/ocf_pkg.sv */
// Shared constants, types and the byte-wise CRC-32 function for the Ogg page framer.
// No dependencies; the framer core, page tracker and CRC unit import this package.
package ocf_pkg;

  localparam int unsigned PosW = 17;
  localparam int unsigned LenW = 16;
  localparam int unsigned CrcW = 32;

  localparam logic [CrcW-1:0] CrcPoly     = 32'h04C1_1DB7;
  localparam logic [PosW-1:0] HeaderBytes = 17'd27;
  localparam logic [PosW-1:0] CksumFirst  = 17'd22;
  localparam logic [PosW-1:0] CksumLast   = 17'd25;
  localparam logic [PosW-1:0] SegCountPos = 17'd26;

  typedef logic [PosW-1:0] pos_t;
  typedef logic [LenW-1:0] len_t;
  typedef logic [CrcW-1:0] crc_t;

  typedef struct packed {
    logic [7:0] eff_byte;
    logic       last;
    len_t       length;
  } page_info_t;

  function automatic crc_t crc_byte(input crc_t crc, input logic [7:0] b);
    crc_t r;
    r = crc ^ {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      if (r[CrcW-1]) begin
        r = {r[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[CrcW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

/* src/ocf_in_if.sv */
// Input channel of the Ogg page framer: one raw stream byte per item.
// Depends on nothing.
interface ocf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

/* src/ocf_out_if.sv */
// Output channel of the Ogg page framer: framed byte plus page end, CRC and length.
// Depends on nothing.
interface ocf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_in_page;
  logic [31:0] page_crc;
  logic [15:0] page_length;

  modport source(output valid, output out_byte, output last_in_page, output page_crc,
                 output page_length, input ready);
  modport sink(input valid, input out_byte, input last_in_page, input page_crc,
               input page_length, output ready);
endinterface

/* src/ogg_page_crc_framer_core.sv */
// The framer takes one byte of an Ogg stream per item, the first at a page boundary, and gives
// one result per byte: the byte with the checksum field forced to zero, and on the last byte of
// the page the page CRC-32 and the page length. It accepts one item every cycle unless the result
// register is full and not being read; each item passes through the input register and then the
// result register, and the throughput is set by the byte-wide CRC update and page counters between them.
// Depends on ocf_pkg, ocf_in_if, ocf_out_if, ocf_page_tracker and ocf_crc_unit.
module ogg_page_crc_framer_core
  import ocf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  ocf_in_if.sink    in_i,
  ocf_out_if.source out_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;
  page_info_t info;
  crc_t       crc_next;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  crc_t       out_crc_q;
  len_t       out_len_q;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
    end
  end

  ocf_page_tracker u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .info_o (info)
  );

  ocf_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .info_i (info),
    .crc_o  (crc_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= info.eff_byte;
      out_last_q <= info.last;
      out_crc_q  <= info.last ? crc_next : '0;
      out_len_q  <= info.last ? info.length : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.last_in_page = out_last_q;
  assign out_o.page_crc     = out_crc_q;
  assign out_o.page_length  = out_len_q;

`ifndef NO_ASSERTIONS
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("pending input item lost while stalled");
  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after a step");
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_len_q == '0 && out_crc_q == '0)
    else $error("length or CRC shown on a byte that does not end the page");
`endif

endmodule

/* src/ocf_page_tracker.sv */
// Page position, segment count and segment table sum, with page end detection.
// Depends on ocf_pkg.
module ocf_page_tracker
  import ocf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output page_info_t info_o
);

  pos_t       pos_q, pos_d;
  logic [7:0] seg_q, seg_d;
  len_t       sum_q, sum_d;
  pos_t       seg_n;
  pos_t       len_full;
  logic       in_cksum;
  logic       in_table;
  logic       end_ok;
  logic       last;

  always_comb begin
    in_cksum = (pos_q >= CksumFirst) && (pos_q <= CksumLast);
    in_table = (pos_q >= HeaderBytes) && (pos_q <= SegCountPos + PosW'(seg_q));
    seg_d    = (pos_q == SegCountPos) ? byte_i : seg_q;
    if (pos_q == SegCountPos) begin
      sum_d = '0;
    end else if (in_table) begin
      sum_d = sum_q + LenW'(byte_i);
    end else begin
      sum_d = sum_q;
    end
    seg_n    = PosW'(seg_d);
    len_full = HeaderBytes + seg_n + PosW'(sum_d);
    end_ok   = (pos_q >= SegCountPos) && (pos_q >= SegCountPos + seg_n);
    last     = end_ok && ((pos_q + PosW'(1)) == len_full);
    pos_d    = pos_q + PosW'(1);
  end

  assign info_o.eff_byte = in_cksum ? 8'h00 : byte_i;
  assign info_o.last     = last;
  assign info_o.length   = len_full[LenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      seg_q <= '0;
      sum_q <= '0;
    end else if (step_i) begin
      if (last) begin
        pos_q <= '0;
        seg_q <= '0;
        sum_q <= '0;
      end else begin
        pos_q <= pos_d;
        seg_q <= seg_d;
        sum_q <= sum_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_last_after_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last |-> pos_q >= SegCountPos)
    else $error("page end seen before the segment count byte");
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last |=> pos_q == '0 && sum_q == '0)
    else $error("page state not cleared after page end");
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !last |=> pos_q == $past(pos_q) + PosW'(1))
    else $error("byte position did not advance by one");
`endif

endmodule

/* src/ocf_crc_unit.sv */
// Running page CRC-32 register, cleared at each page end.
// Depends on ocf_pkg.
module ocf_crc_unit
  import ocf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  page_info_t info_i,
  output crc_t       crc_o
);

  crc_t crc_q, crc_d;

  assign crc_d = crc_byte(crc_q, info_i.eff_byte);
  assign crc_o = crc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else if (step_i) begin
      crc_q <= info_i.last ? '0 : crc_d;
    end
  end

endmodule

/* bench/ogg_page_crc_framer_core_tb.sv */
`timescale 1ns / 1ps
// Testbench for ogg_page_crc_framer_core: streams Ogg pages byte by byte under varied idling
// and checks every framed byte, page CRC and page length against a built-in page predictor.
// Depends on ocf_pkg, ocf_in_if, ocf_out_if and the framer RTL.
module ogg_page_crc_framer_core_tb;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned PhaseBytes = 300;
  localparam int unsigned DrainCycles = 10;

  localparam int unsigned HdrRandom = 0;
  localparam int unsigned HdrAlternate = 1;
  localparam int unsigned HdrOnes = 2;

  localparam int unsigned NumPhases = 4;
  localparam int unsigned SendIdlePct[NumPhases] = '{0, 50, 0, 25};
  localparam int unsigned RecvStallPct[NumPhases] = '{0, 0, 50, 25};

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] crc;
    logic [15:0] length;
  } framed_byte_t;

  class page_frame_predictor;
    localparam logic [31:0] GenPoly = 32'h04C1_1DB7;
    localparam int unsigned HeaderLen = 27;
    localparam int unsigned ChkFirst = 22;
    localparam int unsigned ChkLast = 25;
    localparam int unsigned SegCountAt = 26;
    localparam int unsigned PrintCap = 50;

    int unsigned  page_offset;
    int unsigned  seg_total;
    int unsigned  body_bytes;
    logic [31:0]  running_crc;
    framed_byte_t expected_out[$];
    int unsigned  errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      page_offset = 0;
      seg_total = 0;
      body_bytes = 0;
      running_crc = '0;
    endfunction

    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[31] ^ b[i];
        c = {c[30:0], 1'b0};
        if (fb) begin
          c = c ^ GenPoly;
        end
      end
      return c;
    endfunction

    function void report(string msg);
      if (errors < PrintCap) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      errors++;
    endfunction

    function void note_byte(logic [7:0] b);
      framed_byte_t e;
      logic [7:0]   eff;
      int unsigned  total;
      eff = (page_offset >= ChkFirst && page_offset <= ChkLast) ? 8'h00 : b;
      running_crc = crc_step(running_crc, eff);
      if (page_offset == SegCountAt) begin
        seg_total = b;
        body_bytes = 0;
      end else if (page_offset >= HeaderLen && page_offset <= SegCountAt + seg_total) begin
        body_bytes = (body_bytes + b) & 16'hFFFF;
      end
      e = '{data: eff, last: 1'b0, crc: '0, length: '0};
      if (page_offset >= SegCountAt && page_offset >= SegCountAt + seg_total) begin
        total = HeaderLen + seg_total + body_bytes;
        if (page_offset + 1 == total) begin
          e.last = 1'b1;
          e.crc = running_crc;
          e.length = total[15:0];
        end
      end
      expected_out.push_back(e);
      if (e.last) begin
        restart();
      end else begin
        page_offset = (page_offset + 1) & 17'h1FFFF;
      end
    endfunction

    function void check_result(framed_byte_t got);
      framed_byte_t e;
      if (expected_out.size() == 0) begin
        report($sformatf("unexpected result byte=%0h last=%0b", got.data, got.last));
        return;
      end
      e = expected_out.pop_front();
      if (got.data !== e.data) begin
        report($sformatf("out_byte got %0h exp %0h", got.data, e.data));
      end
      if (got.last !== e.last) begin
        report($sformatf("last_in_page got %0b exp %0b", got.last, e.last));
      end
      if (got.crc !== e.crc) begin
        report($sformatf("page_crc got %0h exp %0h", got.crc, e.crc));
      end
      if (got.length !== e.length) begin
        report($sformatf("page_length got %0d exp %0d", got.length, e.length));
      end
    endfunction

    function int unsigned pending();
      return expected_out.size();
    endfunction

    function void drain_check();
      if (expected_out.size() != 0) begin
        report($sformatf("%0d results never arrived", expected_out.size()));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ocf_in_if  in_if();
  ocf_out_if out_if();

  ogg_page_crc_framer_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  page_frame_predictor framer_model = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent_bytes = 0;
  int unsigned cycle_count = 0;

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      framer_model.check_result('{data: out_if.out_byte, last: out_if.last_in_page,
                                  crc: out_if.page_crc, length: out_if.page_length});
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** ogg_page_crc_framer_core: FAILED **");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    framer_model.note_byte(b);
    sent_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_page(input int unsigned segs, input int unsigned seg_hi,
                           input int unsigned hdr_kind);
    logic [7:0]  lacing[$];
    int unsigned body_len;
    logic [7:0]  hdr_b;
    body_len = 0;
    for (int i = 0; i < segs; i++) begin
      if (seg_hi >= 255) begin
        lacing.push_back(8'hFF);
      end else if (seg_hi != 0 && segs <= 4 && $urandom_range(99) < 4) begin
        lacing.push_back(8'hFF);
      end else begin
        lacing.push_back(8'($urandom_range(seg_hi)));
      end
      body_len += lacing[i];
    end
    for (int i = 0; i < 26; i++) begin
      case (hdr_kind)
        HdrAlternate: hdr_b = (i % 2 == 0) ? 8'h00 : 8'hFF;
        HdrOnes: hdr_b = 8'hFF;
        default: hdr_b = 8'($urandom_range(255));
      endcase
      send_byte(hdr_b);
    end
    send_byte(8'(segs));
    foreach (lacing[i]) begin
      send_byte(lacing[i]);
    end
    for (int i = 0; i < body_len; i++) begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic send_random_page();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_page($urandom_range(6), 20, HdrRandom);
    end else if (pick < 90) begin
      send_page($urandom_range(40, 7), 8, HdrRandom);
    end else begin
      send_page($urandom_range(255, 41), 2, HdrRandom);
    end
  endtask

  initial begin
    int unsigned phase_start;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty segment table, then a table of zero-length segments.
    send_page(0, 0, HdrAlternate);
    send_page(2, 0, HdrOnes);

    for (int ph = 0; ph < NumPhases; ph++) begin
      send_idle_pct = SendIdlePct[ph];
      recv_stall_pct = RecvStallPct[ph];
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < PhaseBytes) begin
        send_random_page();
      end
    end

    in_if.valid <= 1'b0;
    recv_stall_pct = 0;
    while (framer_model.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    framer_model.drain_check();
    if (framer_model.errors == 0) begin
      $display("** ogg_page_crc_framer_core: PASSED **");
    end else begin
      $display("** ogg_page_crc_framer_core: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ocf_pkg.sv
src/ocf_in_if.sv
src/ocf_out_if.sv
src/ocf_page_tracker.sv
src/ocf_crc_unit.sv
src/ogg_page_crc_framer_core.sv
bench/ogg_page_crc_framer_core_tb.sv
